/* sv/erfinv_pkg.sv */
// Shared types, widths and polynomial constants for the inverse error function pipeline.
`timescale 1ns / 1ps
`default_nettype none
package erfinv_pkg;

	localparam int KW = 6;          // leading-one index, covers x up to 64 bits
	localparam int MW = 31;         // normalized mantissa, Q30
	localparam int FW = 24;         // fraction bits of log2 and of t
	localparam int TW = 30;         // magnitude of t
	localparam int PW = 64;         // Horner accumulator, signed Q56
	localparam int SQ_CELLS = FW;   // one squaring cell per log2 fraction bit
	localparam int H_CELLS = 9;     // Horner steps, far polynomial padded with a zero term

	localparam logic [31:0]   LN2_Q32 = 32'd2977044472;
	localparam logic [TW-1:0] T_SPLIT = 30'd102760448;   // 6.125 in Q24
	localparam logic [62:0]   P_LIMIT = 63'h4000_0000_0000_0000;
	localparam logic [18:0]   RES_MAX = 19'h3FFFF;
	localparam logic [18:0]   RES_MIN = 19'h40000;

	typedef struct packed {
		logic          sat;
		logic          a_neg;
		logic [15:0]   ua;
		logic [KW-1:0] k;
		logic [MW-1:0] m;
		logic [FW-1:0] frac;
	} log_item_t;

	typedef struct packed {
		logic          sat;
		logic          a_neg;
		logic [15:0]   ua;
		logic          far;
		logic [TW-1:0] tmag;
		logic [PW-1:0] p;
	} poly_item_t;

	localparam logic [PW-1:0] NEAR_TOP = 64'h175c000 << 4;

	// Horner coefficient of order idx, Q56
	function automatic logic [PW-1:0] coef(input logic far, input logic [3:0] idx);
		logic [PW-1:0] c;
		c = '0;
		if (far) begin
			case (idx)
				4'd0: c = 64'h1ae16a4 << 31;
				4'd1: c = -(64'h10eff66 << 30);
				4'd2: c = 64'h13ca920 << 24;
				4'd3: c = 64'h18cc0de << 23;
				4'd4: c = 64'h19cab92 << 20;
				4'd5: c = 64'h1dca7de << 16;
				4'd6: c = 64'h147e512 << 12;
				4'd7: c = 64'h1f7c9ae << 6;
				4'd8: c = 64'h14deb44;
				default: c = '0;
			endcase
		end else begin
			case (idx)
				4'd0: c = 64'h1c5bf88 << 31;
				4'd1: c = -(64'h1db2aee << 29);
				4'd2: c = 64'h17a1e50 << 25;
				4'd3: c = 64'h12f6400 << 23;
				4'd4: c = -(64'h135be90 << 19);
				4'd5: c = -(64'h1d70bd0 << 17);
				4'd6: c = 64'h1e52cd2 << 8;
				4'd7: c = 64'h1499232 << 12;
				4'd8: c = 64'h133b402 << 9;
				default: c = '0;
			endcase
		end
		return c;
	endfunction

endpackage
`default_nettype wire

/* sv/inverse_error_function.sv */
// Top level of the inverse error function pipeline.
//
// Computes erfinv(a) for a signed Q1.15 argument a_value and returns a signed
// Q3.16 result, rounded to nearest. a_value = -1 (0x8000) has an infinite
// log; the result is clamped to the most negative code and saturated is set.
// saturated also flags any other result that hits the 19-bit limits.
//
// Channels: input (in_valid/in_ready, a_value) and output (out_valid/
// out_ready, result, saturated), both valid/ready.
// Structure: three front stages (x = 1 - a*a, leading one, normalize), a row
// of 24 squaring cells that each produce one log2 fraction bit, two stages
// scaling by ln 2, nine Horner cells of three stages each (two partial
// products of p*t, then round, add coefficient, clamp), and three output
// stages. Throughput is one item per cycle while out_ready is not held low.
// Each stage holds its own valid bit, so a stalled receiver only backs up
// the pipe stage by stage; bubbles are squeezed out and new items are taken
// until every stage is full. Reset clears all valid bits; no other state.
`timescale 1ns / 1ps
`default_nettype none
module inverse_error_function #(
	parameter int INPUT_FRAC_BITS  = 15,
	parameter int OUTPUT_FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [15:0] a_value,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [18:0]      result,
	output logic                    saturated
);
	localparam int SQN = erfinv_pkg::SQ_CELLS;
	localparam int HN  = erfinv_pkg::H_CELLS;
	localparam int TW  = erfinv_pkg::TW;
	localparam int FW  = erfinv_pkg::FW;
	localparam logic [29:0] DTOP = 30'(2 * INPUT_FRAC_BITS) << FW;

	erfinv_pkg::log_item_t  lc_item  [SQN+1];
	logic                   lc_valid [SQN+1];
	logic                   lc_ready [SQN+1];
	erfinv_pkg::poly_item_t pc_item  [HN+1];
	logic                   pc_valid [HN+1];
	logic                   pc_ready [HN+1];

	// front: x = 1 - a*a, normalized mantissa
	erfinv_front #(.IFB(INPUT_FRAC_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (in_valid),
		.up_ready (in_ready),
		.a_value  (a_value),
		.dn_valid (lc_valid[0]),
		.dn_ready (lc_ready[0]),
		.dn_item  (lc_item[0])
	);

	// log2 fraction, one bit per cell
	generate
		for (genvar i = 0; i < SQN; i++) begin : g_sq
			erfinv_sq_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.up_valid (lc_valid[i]),
				.up_ready (lc_ready[i]),
				.up_item  (lc_item[i]),
				.dn_valid (lc_valid[i+1]),
				.dn_ready (lc_ready[i+1]),
				.dn_item  (lc_item[i+1])
			);
		end
	endgenerate

	// t = -ln(x): log2 distance from one, times ln 2 in Q32
	logic        tv_s1, tv_s2, tr1, tr2;
	logic        tsat_s1, tneg_s1;
	logic [15:0] tua_s1;
	logic [61:0] tprod_s1;
	erfinv_pkg::poly_item_t titem_s2;
	logic [29:0]   dmag_c;
	logic [TW-1:0] tmag_c;

	assign tr2 = !tv_s2 || pc_ready[0];
	assign tr1 = !tv_s1 || tr2;
	assign lc_ready[SQN] = tr1;

	assign dmag_c = DTOP - {lc_item[SQN].k, lc_item[SQN].frac};
	assign tmag_c = TW'(({1'b0, tprod_s1} + 63'h80000000) >> 32);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tv_s1 <= 1'b0;
			tv_s2 <= 1'b0;
		end else begin
			if (tr1) tv_s1 <= lc_valid[SQN];
			if (tr2) tv_s2 <= tv_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (tr1 && lc_valid[SQN]) begin
			tsat_s1  <= lc_item[SQN].sat;
			tneg_s1  <= lc_item[SQN].a_neg;
			tua_s1   <= lc_item[SQN].ua;
			tprod_s1 <= 62'(dmag_c) * 62'(erfinv_pkg::LN2_Q32);
		end
		if (tr2 && tv_s1) begin
			titem_s2.sat   <= tsat_s1;
			titem_s2.a_neg <= tneg_s1;
			titem_s2.ua    <= tua_s1;
			titem_s2.tmag  <= tmag_c;
			// far branch starts from zero so both run nine steps
			titem_s2.far   <= tmag_c > erfinv_pkg::T_SPLIT;
			titem_s2.p     <= (tmag_c > erfinv_pkg::T_SPLIT) ? '0 : erfinv_pkg::NEAR_TOP;
		end
	end

	assign pc_valid[0] = tv_s2;
	assign pc_item[0]  = titem_s2;

	// Horner evaluation, highest order first
	generate
		for (genvar j = 0; j < HN; j++) begin : g_h
			erfinv_horner_cell #(.IDX(j)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.up_valid (pc_valid[j]),
				.up_ready (pc_ready[j]),
				.up_item  (pc_item[j]),
				.dn_valid (pc_valid[j+1]),
				.dn_ready (pc_ready[j+1]),
				.dn_item  (pc_item[j+1])
			);
		end
	endgenerate

	// scale by a, round, clamp; last register drives the output port
	erfinv_back #(.IFB(INPUT_FRAC_BITS), .OFB(OUTPUT_FRAC_BITS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.up_valid     (pc_valid[HN]),
		.up_ready     (pc_ready[HN]),
		.up_item      (pc_item[HN]),
		.dn_valid     (out_valid),
		.dn_ready     (out_ready),
		.dn_result    (result),
		.dn_saturated (saturated)
	);

	// clamped results sit exactly on a range limit
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> (result == $signed(19'h40000) || result == 19'sd262143))
		else $error("saturated result off the range limit");

	// normalized mantissa keeps its leading one through every squaring cell
	a_mant_norm: assert property (@(posedge clk) disable iff (!arst_n)
		lc_valid[SQN] && !lc_item[SQN].sat |-> lc_item[SQN].m[erfinv_pkg::MW-1])
		else $error("log mantissa lost normalization");

	// Horner accumulator stays within +-2^62
	a_p_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_valid[HN] |-> ($signed(pc_item[HN].p) <= 64'sh4000000000000000
			&& $signed(pc_item[HN].p) >= -64'sh4000000000000000))
		else $error("polynomial value out of clamp range");

endmodule
`default_nettype wire

/* sv/erfinv_front.sv */
// Front stages: |a|, x = 1 - a*a, leading-one search and mantissa normalize.
`timescale 1ns / 1ps
`default_nettype none
module erfinv_front #(
	parameter int IFB = 15
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  up_valid,
	output logic                       up_ready,
	input  wire logic signed [15:0]    a_value,
	output logic                       dn_valid,
	input  wire logic                  dn_ready,
	output erfinv_pkg::log_item_t      dn_item
);
	localparam int XW = 2 * IFB + 1;
	localparam logic [63:0] ONE = 64'd1 << (2 * IFB);
	localparam int KW = erfinv_pkg::KW;
	localparam int MW = erfinv_pkg::MW;

	logic          v_s1, v_s2, v_s3;
	logic          r1, r2, r3;
	logic          neg_s1, neg_s2, sat_s1, sat_s2;
	logic [15:0]   ua_s1, ua_s2;
	logic [XW-1:0] x_s1, x_s2;
	logic [KW-1:0] k_s2;
	erfinv_pkg::log_item_t item_s3;

	logic [15:0]   ua_c;
	logic [31:0]   sq_c;
	logic          sat_c;
	logic [XW-1:0] x_c;
	logic [KW-1:0] k_c;
	logic [KW-1:0] sh_c;
	logic [XW-1:0] norm_c;
	logic [MW-1:0] m_c;

	assign r3 = !v_s3 || dn_ready;
	assign r2 = !v_s2 || r3;
	assign r1 = !v_s1 || r2;
	assign up_ready = r1;

	always_comb begin
		ua_c = a_value[15] ? 16'(-a_value) : a_value;
		sq_c = 32'(ua_c) * 32'(ua_c);
		sat_c = {32'b0, sq_c} >= ONE;
		x_c = XW'(ONE - {32'b0, sq_c});
	end

	// highest set bit wins
	always_comb begin
		k_c = '0;
		for (int i = 0; i < XW; i++) begin
			if (x_s1[i]) k_c = KW'(i);
		end
	end

	assign sh_c = KW'(XW - 1) - k_s2;
	assign norm_c = x_s2 << sh_c;

	generate
		if (XW >= MW) begin : g_trunc
			assign m_c = norm_c[XW-1 -: MW];
		end else begin : g_pad
			assign m_c = {norm_c, {(MW - XW){1'b0}}};
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (r1) v_s1 <= up_valid;
			if (r2) v_s2 <= v_s1;
			if (r3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (r1 && up_valid) begin
			neg_s1 <= a_value[15];
			ua_s1  <= ua_c;
			sat_s1 <= sat_c;
			x_s1   <= x_c;
		end
		if (r2 && v_s1) begin
			neg_s2 <= neg_s1;
			ua_s2  <= ua_s1;
			sat_s2 <= sat_s1;
			x_s2   <= x_s1;
			k_s2   <= k_c;
		end
		if (r3 && v_s2) begin
			item_s3.sat   <= sat_s2;
			item_s3.a_neg <= neg_s2;
			item_s3.ua    <= ua_s2;
			item_s3.k     <= k_s2;
			item_s3.m     <= m_c;
			item_s3.frac  <= '0;
		end
	end

	assign dn_valid = v_s3;
	assign dn_item  = item_s3;
endmodule
`default_nettype wire

/* sv/erfinv_sq_cell.sv */
// One log2 cell: squares the mantissa and yields one fraction bit.
`timescale 1ns / 1ps
`default_nettype none
module erfinv_sq_cell (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   up_valid,
	output logic                        up_ready,
	input  wire erfinv_pkg::log_item_t  up_item,
	output logic                        dn_valid,
	input  wire logic                   dn_ready,
	output erfinv_pkg::log_item_t       dn_item
);
	localparam int MW = erfinv_pkg::MW;
	localparam int FW = erfinv_pkg::FW;

	logic                  valid_q;
	erfinv_pkg::log_item_t item_q;
	erfinv_pkg::log_item_t nxt_c;
	logic [2*MW-1:0]       sq_c;
	logic [MW:0]           top_c;

	assign up_ready = !valid_q || dn_ready;

	always_comb begin
		nxt_c = up_item;
		sq_c  = (2*MW)'(up_item.m) * (2*MW)'(up_item.m);
		top_c = sq_c[2*MW-1:MW-1];
		if (top_c[MW]) begin
			nxt_c.m    = top_c[MW:1];
			nxt_c.frac = {up_item.frac[FW-2:0], 1'b1};
		end else begin
			nxt_c.m    = top_c[MW-1:0];
			nxt_c.frac = {up_item.frac[FW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) item_q <= nxt_c;
	end

	assign dn_valid = valid_q;
	assign dn_item  = item_q;
endmodule
`default_nettype wire

/* sv/erfinv_horner_cell.sv */
// One Horner step p = clamp(round(p*t) + c): high product, low product, combine.
`timescale 1ns / 1ps
`default_nettype none
module erfinv_horner_cell #(
	parameter int IDX = 0
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    up_valid,
	output logic                         up_ready,
	input  wire erfinv_pkg::poly_item_t  up_item,
	output logic                         dn_valid,
	input  wire logic                    dn_ready,
	output erfinv_pkg::poly_item_t       dn_item
);
	localparam int PW = erfinv_pkg::PW;
	localparam logic [3:0] CIDX = 4'(erfinv_pkg::H_CELLS - 1 - IDX);
	localparam logic [63:0] PLIM = {1'b0, erfinv_pkg::P_LIMIT};

	logic v_s1, v_s2, v_s3, r1, r2, r3;
	erfinv_pkg::poly_item_t item_s1, item_s2, item_s3;
	logic [62:0] up_s1;
	logic [60:0] hi_s1, hi_s2;
	logic [61:0] lo_s2;

	logic [63:0] pabs_c;
	logic [60:0] hi_c;
	logic [61:0] lo_c;
	logic [63:0] mag_c;
	logic [64:0] mt_c, sum_c, sabs_c;
	logic [PW-1:0] cf_c, p_c;
	erfinv_pkg::poly_item_t out_c;

	assign r3 = !v_s3 || dn_ready;
	assign r2 = !v_s2 || r3;
	assign r1 = !v_s1 || r2;
	assign up_ready = r1;

	always_comb begin
		pabs_c = up_item.p[PW-1] ? -up_item.p : up_item.p;
		hi_c   = 61'(pabs_c[62:32]) * 61'(up_item.tmag);
		lo_c   = 62'(up_s1[31:0]) * 62'(item_s1.tmag);
	end

	// the step multiplies by -t, so the product takes the opposite sign of p
	always_comb begin
		if (hi_s2 > (61'd1 << 54)) begin
			mag_c = PLIM;
		end else begin
			mag_c = ({3'b0, hi_s2} << 8) + 64'(({2'b0, lo_s2} + 64'd8388608) >> 24);
		end
		if (mag_c > PLIM) mag_c = PLIM;
		mt_c   = item_s2.p[PW-1] ? {1'b0, mag_c} : -{1'b0, mag_c};
		cf_c   = erfinv_pkg::coef(item_s2.far, CIDX);
		sum_c  = mt_c + {cf_c[PW-1], cf_c};
		sabs_c = sum_c[64] ? -sum_c : sum_c;
		if (sabs_c > {1'b0, PLIM}) sabs_c = {1'b0, PLIM};
		p_c = sum_c[64] ? -sabs_c[63:0] : sabs_c[63:0];
		out_c   = item_s2;
		out_c.p = p_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (r1) v_s1 <= up_valid;
			if (r2) v_s2 <= v_s1;
			if (r3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (r1 && up_valid) begin
			item_s1 <= up_item;
			up_s1   <= pabs_c[62:0];
			hi_s1   <= hi_c;
		end
		if (r2 && v_s1) begin
			item_s2 <= item_s1;
			hi_s2   <= hi_s1;
			lo_s2   <= lo_c;
		end
		if (r3 && v_s2) begin
			item_s3 <= out_c;
		end
	end

	assign dn_valid = v_s3;
	assign dn_item  = item_s3;
endmodule
`default_nettype wire

/* sv/erfinv_back.sv */
// Back stages: round p to Q32, multiply by |a|, round to output format and clamp.
`timescale 1ns / 1ps
`default_nettype none
module erfinv_back #(
	parameter int IFB = 15,
	parameter int OFB = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    up_valid,
	output logic                         up_ready,
	input  wire erfinv_pkg::poly_item_t  up_item,
	output logic                         dn_valid,
	input  wire logic                    dn_ready,
	output logic signed [18:0]           dn_result,
	output logic                         dn_saturated
);
	localparam int SH = IFB + 32 - OFB;
	localparam logic [55:0] RND = 56'd1 << (SH - 1);

	logic v_s1, v_s2, v_s3, r1, r2, r3;
	logic sat_s1, sat_s2, aneg_s1, aneg_s2, rneg_s1, rneg_s2;
	logic [15:0] ua_s1;
	logic [38:0] pmag_s1;
	logic [54:0] prod_s2;
	logic [18:0] res_s3;
	logic        satf_s3;

	logic [63:0] pabs_c;
	logic [55:0] mag_c;
	logic [18:0] res_c;
	logic        satf_c;

	assign r3 = !v_s3 || dn_ready;
	assign r2 = !v_s2 || r3;
	assign r1 = !v_s1 || r2;
	assign up_ready = r1;

	assign pabs_c = up_item.p[63] ? -up_item.p : up_item.p;

	always_comb begin
		mag_c  = 56'(({1'b0, prod_s2} + RND) >> SH);
		satf_c = 1'b0;
		if (sat_s2) begin
			res_c  = aneg_s2 ? erfinv_pkg::RES_MIN : erfinv_pkg::RES_MAX;
			satf_c = 1'b1;
		end else if (rneg_s2) begin
			if (mag_c > 56'd262144) begin
				res_c  = erfinv_pkg::RES_MIN;
				satf_c = 1'b1;
			end else begin
				res_c = -mag_c[18:0];
			end
		end else begin
			if (mag_c > 56'd262143) begin
				res_c  = erfinv_pkg::RES_MAX;
				satf_c = 1'b1;
			end else begin
				res_c = mag_c[18:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (r1) v_s1 <= up_valid;
			if (r2) v_s2 <= v_s1;
			if (r3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (r1 && up_valid) begin
			sat_s1  <= up_item.sat;
			aneg_s1 <= up_item.a_neg;
			rneg_s1 <= up_item.a_neg ^ up_item.p[63];
			ua_s1   <= up_item.ua;
			pmag_s1 <= 39'((pabs_c + 64'd8388608) >> 24);
		end
		if (r2 && v_s1) begin
			sat_s2  <= sat_s1;
			aneg_s2 <= aneg_s1;
			rneg_s2 <= rneg_s1;
			prod_s2 <= 55'(ua_s1) * 55'(pmag_s1);
		end
		if (r3 && v_s2) begin
			res_s3  <= res_c;
			satf_s3 <= satf_c;
		end
	end

	assign dn_valid     = v_s3;
	assign dn_result    = res_s3;
	assign dn_saturated = satf_s3;
endmodule
`default_nettype wire
